>>> rtl/rbf_pkg.sv
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared types, state codes and the elaboration-time exponential table
// builder for the Gaussian RBF network evaluator.
// ----------------------------------------------------------------------------
package rbf_pkg;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam int OUT_W = 24;

	// One input beat as it moves from front to back
	typedef struct packed {
		logic               mode;
		logic [5:0]         index;
		logic signed [15:0] center;
		logic [15:0]        width;
		logic signed [15:0] weight;
		logic signed [15:0] sample;
		logic signed [15:0] target;
	} item_t;

	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_EVAL = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOAD,
		BK_EVAL,
		BK_DRAIN,
		BK_FIN
	} back_st_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_SQ,
		DV_INIT,
		DV_RUN
	} div_st_t;

	// exp(-f) in Q30 for f in [0, 1] in Q30, by Taylor series
	function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
		logic signed [63:0] sum;
		logic [63:0]        term;
		sum  = '0;
		term = Q30_ONE;
		for (int i = 0; i < 18; i++) begin
			if (i[0]) sum = sum - $signed(term);
			else      sum = sum + $signed(term);
			term = ((term * f) >> 30) / 64'(i + 1);
		end
		if (sum < 0) sum = '0;
		if (sum > $signed(Q30_ONE)) sum = $signed(Q30_ONE);
		return $unsigned(sum);
	endfunction

	// Table entry exp(-t) in Q16 for an argument t in Q30
	function automatic logic [16:0] exp_entry(input logic [63:0] t);
		logic [63:0] e1;
		logic [63:0] n;
		logic [63:0] f;
		logic [63:0] en;
		logic [63:0] r;
		e1 = exp_neg_frac(Q30_ONE);
		n  = t >> 30;
		f  = t & (Q30_ONE - 64'd1);
		en = Q30_ONE;
		for (int j = 0; j < 16; j++) begin
			if (64'(j) < n) en = (en * e1 + (64'd1 << 29)) >> 30;
		end
		r = (en * exp_neg_frac(f) + (64'd1 << 43)) >> 44;
		return r[16:0];
	endfunction

endpackage

>>> rtl/gaussian_rbf_network_eval.sv
// An evaluate streams min(bases_in_use, NUM_BASES) entries through the pipeline, drains
// it and then strobes its result; a zero count goes straight to the drain.
// A load runs take, square, setup, a 40-step divider and write. The back end finishes
// one command before it takes the next. A two-beat queue takes commands
// meanwhile; busy when full. The receiver cannot stall results.
// Reset clears control and sets bases_in_use to 41; basis stores are undefined until loaded.
// ----------------------------------------------------------------------------
// gaussian_rbf_network_eval
// One-dimensional Gaussian RBF network evaluator: front queue, back-end
// executor and the bases_in_use register.
// ----------------------------------------------------------------------------
module gaussian_rbf_network_eval #(
	parameter int NUM_BASES       = 64,
	parameter int EXP_TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic [5:0]         index,
	input  logic signed [15:0] center,
	input  logic [15:0]        width,
	input  logic signed [15:0] weight,
	input  logic signed [15:0] sample,
	input  logic signed [15:0] target,
	input  logic               cfg_wr_en,
	input  logic [6:0]         cfg_wr_data,
	output logic               result_valid,
	output logic signed [23:0] network_output,
	output logic signed [23:0] residual,
	output logic               saturated
);

	rbf_pkg::item_t item_in;
	rbf_pkg::item_t item_q;
	logic           item_valid;
	logic           item_pop;
	logic [6:0]     bases_q;

	assign item_in = '{mode: mode, index: index, center: center, width: width,
	                   weight: weight, sample: sample, target: target};

	// Hold configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bases_q <= 7'd41;
		else if (cfg_wr_en) bases_q <= cfg_wr_data;
	end

	rbf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item_in    (item_in),
		.item_valid (item_valid),
		.item_out   (item_q),
		.item_pop   (item_pop)
	);

	rbf_back #(
		.NUM_BASES       (NUM_BASES),
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item           (item_q),
		.item_pop       (item_pop),
		.bases_in_use   (bases_q),
		.result_valid   (result_valid),
		.network_output (network_output),
		.residual       (residual),
		.saturated      (saturated)
	);

endmodule

>>> rtl/rbf_front.sv
// ----------------------------------------------------------------------------
// rbf_front
// Accepts command beats and holds them in a two-entry queue until the
// back end is free to take them.
// ----------------------------------------------------------------------------
module rbf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rbf_pkg::item_t item_in,
	output logic           item_valid,
	output rbf_pkg::item_t item_out,
	input  logic           item_pop
);

	rbf_pkg::item_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;

	assign busy       = (fill_q == 2'd2);
	assign push       = start && !busy;
	assign item_valid = (fill_q != 2'd0);
	assign item_out   = slot_q[rd_ptr_q];

	// Store accepted beat
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= item_in;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (item_pop) rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + 2'(push) - 2'(item_pop);
		end
	end

endmodule

>>> rtl/rbf_div.sv
// ----------------------------------------------------------------------------
// rbf_div
// Works out a basis scale round(2^39 / width^2), saturated to 32 bits,
// with a restoring divider that takes one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbf_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [15:0] wid,
	output logic        done,
	output logic [31:0] scale
);

	rbf_pkg::div_st_t st_q;
	logic [31:0] w2_q;
	logic [39:0] num_q;
	logic [39:0] quo_q;
	logic [32:0] rem_q;
	logic [5:0]  cnt_q;
	logic [32:0] rem_sh;
	logic        qbit;

	assign rem_sh = {rem_q[31:0], num_q[39]};
	assign qbit   = (rem_sh >= {1'b0, w2_q});

	// Sequence square, setup and bit steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= rbf_pkg::DV_IDLE;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				rbf_pkg::DV_IDLE: if (go) st_q <= rbf_pkg::DV_SQ;
				rbf_pkg::DV_SQ:   st_q <= rbf_pkg::DV_INIT;
				rbf_pkg::DV_INIT: begin
					cnt_q <= 6'd40;
					st_q  <= rbf_pkg::DV_RUN;
				end
				rbf_pkg::DV_RUN: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						st_q <= rbf_pkg::DV_IDLE;
						done <= 1'b1;
					end
				end
				default: st_q <= rbf_pkg::DV_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (st_q)
			rbf_pkg::DV_SQ: w2_q <= 32'(wid) * 32'(wid);
			rbf_pkg::DV_INIT: begin
				num_q <= (40'd1 << 39) + 40'(w2_q >> 1);
				rem_q <= '0;
				quo_q <= '0;
			end
			rbf_pkg::DV_RUN: begin
				rem_q <= qbit ? (rem_sh - {1'b0, w2_q}) : rem_sh;
				num_q <= {num_q[38:0], 1'b0};
				quo_q <= {quo_q[38:0], qbit};
			end
			default: ;
		endcase
	end

	assign scale = (w2_q == 32'd0) ? 32'd0 :
	               (quo_q[39:32] != 8'd0) ? 32'hFFFF_FFFF : quo_q[31:0];

endmodule

>>> rtl/rbf_back.sv
// ----------------------------------------------------------------------------
// rbf_back
// Carries out queued commands: a load stores one basis entry after its
// scale is divided out; an evaluate streams the entries through a
// multiply, exponential lookup and accumulate pipeline.
// ----------------------------------------------------------------------------
module rbf_back #(
	parameter int NUM_BASES       = 64,
	parameter int EXP_TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  rbf_pkg::item_t     item,
	output logic               item_pop,
	input  logic [6:0]         bases_in_use,
	output logic               result_valid,
	output logic signed [23:0] network_output,
	output logic signed [23:0] residual,
	output logic               saturated
);

	localparam int AW = (NUM_BASES > 1) ? $clog2(NUM_BASES) : 1;
	localparam int CW = $clog2(NUM_BASES + 1);
	localparam int KW = $clog2(EXP_TABLE_DEPTH);
	localparam int PW = 44 + $clog2(EXP_TABLE_DEPTH + 1);
	localparam int BW = (CW > 7) ? CW : 7;

	rbf_pkg::back_st_t st_q, st_d;

	logic signed [15:0] center_mem [NUM_BASES];
	logic signed [15:0] weight_mem [NUM_BASES];
	logic [31:0]        scale_mem  [NUM_BASES];
	logic [16:0]        exp_rom    [EXP_TABLE_DEPTH];

	rbf_pkg::item_t cur_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  idx_q;
	logic [CW-1:0]  count_d;
	logic           div_go;
	logic           div_done;
	logic [31:0]    div_scale;
	logic           iss;
	logic           load_ok;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [15:0] c_s1;
	logic signed [15:0] w_s1, w_s2, w_s3, w_s4, w_s5;
	logic [31:0]        sc_s1, sc_s2;
	logic               nz_s3;
	logic [31:0]        dsq_s2;
	logic [63:0]        a_s3;
	logic               ok_s4, ok_s5;
	logic [KW-1:0]      k_s4;
	logic [16:0]        e_s5;
	logic signed [33:0] prod_s6;
	logic signed [39:0] acc_q;
	logic signed [16:0] diff;
	logic [16:0]        adiff;
	logic [PW-1:0]      kprod;
	logic signed [25:0] sum12;
	logic signed [26:0] res;

	// Build exponential table at elaboration
	for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
		localparam logic [63:0] TARG = (64'(g) << 34) / EXP_TABLE_DEPTH;
		assign exp_rom[g] = rbf_pkg::exp_entry(TARG);
	end

	rbf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.wid    (cur_q.width),
		.done   (div_done),
		.scale  (div_scale)
	);

	// Clamp requested count to the store depth
	assign count_d = (BW'(bases_in_use) > BW'(NUM_BASES)) ? CW'(NUM_BASES) :
	                 CW'(bases_in_use);
	assign load_ok = (32'(cur_q.index) < 32'(NUM_BASES));

	// Next state and control
	always_comb begin
		st_d     = st_q;
		item_pop = 1'b0;
		div_go   = 1'b0;
		iss      = 1'b0;
		case (st_q)
			rbf_pkg::BK_IDLE: begin
				if (item_valid) begin
					item_pop = 1'b1;
					if (item.mode == rbf_pkg::MODE_LOAD) st_d = rbf_pkg::BK_LOAD;
					else if (count_d == '0)             st_d = rbf_pkg::BK_DRAIN;
					else                                 st_d = rbf_pkg::BK_EVAL;
				end
			end
			rbf_pkg::BK_LOAD: begin
				div_go = !div_done;
				if (div_done) st_d = rbf_pkg::BK_IDLE;
			end
			rbf_pkg::BK_EVAL: begin
				iss = 1'b1;
				if (idx_q + CW'(1) == count_q) st_d = rbf_pkg::BK_DRAIN;
			end
			rbf_pkg::BK_DRAIN: begin
				if (!(v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || v_s6))
					st_d = rbf_pkg::BK_FIN;
			end
			rbf_pkg::BK_FIN: st_d = rbf_pkg::BK_IDLE;
			default: st_d = rbf_pkg::BK_IDLE;
		endcase
	end

	// State and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= rbf_pkg::BK_IDLE;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			v_s5         <= 1'b0;
			v_s6         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			st_q         <= st_d;
			v_s1         <= iss;
			v_s2         <= v_s1;
			v_s3         <= v_s2;
			v_s4         <= v_s3;
			v_s5         <= v_s4;
			v_s6         <= v_s5;
			result_valid <= (st_q == rbf_pkg::BK_FIN);
		end
	end

	// Hold command, counters and accumulator
	always_ff @(posedge clk) begin
		if (item_pop) begin
			cur_q   <= item;
			count_q <= count_d;
			idx_q   <= '0;
			acc_q   <= '0;
		end
		if (iss) idx_q <= idx_q + CW'(1);
		if (v_s6) acc_q <= acc_q + 40'(prod_s6);
	end

	// Write basis entry when the scale is ready
	always_ff @(posedge clk) begin
		if (st_q == rbf_pkg::BK_LOAD && div_done && load_ok) begin
			center_mem[AW'(cur_q.index)] <= cur_q.center;
			weight_mem[AW'(cur_q.index)] <= cur_q.weight;
			scale_mem[AW'(cur_q.index)]  <= div_scale;
		end
	end

	// Stage 1: read entry
	always_ff @(posedge clk) begin
		c_s1  <= center_mem[idx_q[AW-1:0]];
		w_s1  <= weight_mem[idx_q[AW-1:0]];
		sc_s1 <= scale_mem[idx_q[AW-1:0]];
	end

	assign diff  = 17'(cur_q.sample) - 17'(c_s1);
	assign adiff = diff[16] ? 17'(-diff) : 17'(diff);
	assign kprod = PW'(a_s3[43:0]) * PW'(EXP_TABLE_DEPTH);

	// Stages 2 to 6: square, scale, index, lookup, weight
	always_ff @(posedge clk) begin
		dsq_s2  <= 32'(34'(adiff) * 34'(adiff));
		sc_s2   <= sc_s1;
		w_s2    <= w_s1;
		a_s3    <= 64'(dsq_s2) * 64'(sc_s2);
		nz_s3   <= (sc_s2 != 32'd0);
		w_s3    <= w_s2;
		ok_s4   <= nz_s3 && (a_s3[63:44] == 20'd0);
		k_s4    <= kprod[44 +: KW];
		w_s4    <= w_s3;
		e_s5    <= exp_rom[k_s4];
		ok_s5   <= ok_s4;
		w_s5    <= w_s4;
		prod_s6 <= ok_s5 ? 34'(w_s5) * $signed({1'b0, e_s5}) : 34'sd0;
	end

	// Round to Q12, form residual, clip both
	assign sum12 = 26'((acc_q + 40'sd32768) >>> 16);
	assign res   = 27'(cur_q.target) - 27'(sum12);

	always_ff @(posedge clk) begin
		if (st_q == rbf_pkg::BK_FIN) begin
			network_output <= (sum12 > 26'sd8388607)  ? 24'sh7FFFFF :
			                  (sum12 < -26'sd8388608) ? 24'sh800000 : sum12[23:0];
			residual       <= (res > 27'sd8388607)    ? 24'sh7FFFFF :
			                  (res < -27'sd8388608)   ? 24'sh800000 : res[23:0];
			saturated      <= (sum12 > 26'sd8388607) || (sum12 < -26'sd8388608) ||
			                  (res > 27'sd8388607) || (res < -27'sd8388608);
		end
	end

endmodule
